/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the union-find block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("union-find assertion failed");

// Check that a consequence holds in the cycle after its trigger.
`define UF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("union-find assertion failed");

`endif

/* rtl/core/ufss_pkg.sv */
// Package with widths and defaults of the union-find set-size block.
package ufss_pkg;

   // Default element count of the disjoint-set store.
   localparam int NODES_DEF = 1024;

   // Field widths of the stream items.
   localparam int NODE_W = 10;
   localparam int SIZE_W = 11;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Width that holds any element count in the parameter range.
   localparam int CMP_W = 17;

endpackage

/* rtl/core/union_find_set_size.sv */
// Disjoint-set store with set sizes and path compression, one walk step per cycle.
//
//   Channel   Direction  Contents
//   --------  ---------  ---------------------------------------------------
//   req_      in         tuser: mode; tdata: node_a [9:0], node_b [19:10]
//   rsp_      out        tdata: set_size [10:0]
//
// A link item walks from node_a, then from node_b, to the root and points each visited
// entry at that root, then reads both sizes and links; the parent memory, with one
// write and one read port, carries every walk and compression step, one per cycle.
// A clear item runs a pass that writes every entry back to a singleton.
// After reset the same pass runs while req_tready stays low.
// req_tready is high only between items; a waiting result does not block acceptance.
`include "assert_macros.svh"

module union_find_set_size
   import ufss_pkg::*;
#(
   parameter int NODES = NODES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // node_a [9:0], node_b [19:10], zero pad
   input  logic                  req_tuser,   // mode [0]
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // set_size [10:0], zero pad
);

   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [CMP_W-1:0] NODES_LIM = CMP_W'(NODES);
   localparam logic [AW-1:0] LAST_IDX = AW'(NODES - 1);

   // Sequencer states
   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_FIND = 3'd2;
   localparam logic [2:0] ST_COMP = 3'd3;
   localparam logic [2:0] ST_SZA  = 3'd4;
   localparam logic [2:0] ST_SZB  = 3'd5;
   localparam logic [2:0] ST_SZC  = 3'd6;
   localparam logic [2:0] ST_EMIT = 3'd7;

   // Stores
   logic [AW-1:0]     par_mem_ff  [NODES];
   logic [SIZE_W-1:0] size_mem_ff [NODES];
   logic [AW-1:0]     par_q_ff;
   logic [SIZE_W-1:0] size_q_ff;

   // Control and payload registers
   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              clr_item_ff, clr_item_in;
   logic              phase_b_ff, phase_b_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [AW-1:0]     start_ff, start_in;
   logic [AW-1:0]     node_b_ff, node_b_in;
   logic [AW-1:0]     root_a_ff, root_a_in;
   logic [AW-1:0]     root_ff, root_in;
   logic [SIZE_W-1:0] size_a_ff, size_a_in;
   logic [SIZE_W-1:0] res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0] rsp_size_ff, rsp_size_in;

   // Memory port controls
   logic              par_we;
   logic [AW-1:0]     par_waddr, par_wdata, par_raddr;
   logic              size_we;
   logic [AW-1:0]     size_waddr, size_raddr;
   logic [SIZE_W-1:0] size_wdata;

   // Decoded request fields
   logic [NODE_W-1:0] fld_a, fld_b;
   logic              req_oob;
   logic              phase_done;
   logic [AW-1:0]     fin_root;
   logic [SIZE_W-1:0] size_sum;

   assign fld_a   = req_tdata[NODE_W-1:0];
   assign fld_b   = req_tdata[2*NODE_W-1:NODE_W];
   assign req_oob = (CMP_W'(fld_a) >= NODES_LIM) || (CMP_W'(fld_b) >= NODES_LIM);
   assign size_sum = size_a_ff + size_q_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-SIZE_W){1'b0}}, rsp_size_ff};

   // Sequence one item through a clear pass, or walk, compression and link, then emit
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_item_in  = clr_item_ff;
      phase_b_in   = phase_b_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      node_b_in    = node_b_ff;
      root_a_in    = root_a_ff;
      root_in      = root_ff;
      size_a_in    = size_a_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_size_in  = rsp_size_ff;
      par_we       = 1'b0;
      par_waddr    = cur_ff;
      par_wdata    = root_ff;
      par_raddr    = cur_ff;
      size_we      = 1'b0;
      size_waddr   = root_ff;
      size_wdata   = size_sum;
      size_raddr   = root_a_ff;
      phase_done   = 1'b0;
      fin_root     = root_ff;

      case (state_ff)
         ST_CLR: begin
            // write one singleton entry per cycle
            par_we     = 1'b1;
            par_waddr  = clr_ff;
            par_wdata  = clr_ff;
            size_we    = 1'b1;
            size_waddr = clr_ff;
            size_wdata = SIZE_W'(1);
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == LAST_IDX) begin
               clr_in = '0;
               res_in = '0;
               state_in = clr_item_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  clr_in      = '0;
                  clr_item_in = 1'b1;
                  state_in    = ST_CLR;
               end else if (req_oob) begin
                  res_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  cur_in     = AW'(fld_a);
                  start_in   = AW'(fld_a);
                  node_b_in  = AW'(fld_b);
                  phase_b_in = 1'b0;
                  par_raddr  = AW'(fld_a);
                  state_in   = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            // follow parents until an entry points at itself
            if (par_q_ff == cur_ff) begin
               fin_root = cur_ff;
               if (start_ff == cur_ff) begin
                  phase_done = 1'b1;
               end else begin
                  root_in   = cur_ff;
                  cur_in    = start_ff;
                  par_raddr = start_ff;
                  state_in  = ST_COMP;
               end
            end else begin
               cur_in    = par_q_ff;
               par_raddr = par_q_ff;
            end
         end
         ST_COMP: begin
            // point each visited entry straight at the root
            par_we    = 1'b1;
            par_waddr = cur_ff;
            par_wdata = root_ff;
            par_raddr = par_q_ff;
            if (par_q_ff == root_ff) begin
               phase_done = 1'b1;
            end else begin
               cur_in = par_q_ff;
            end
         end
         ST_SZA: begin
            size_raddr = root_a_ff;
            state_in   = ST_SZB;
         end
         ST_SZB: begin
            size_raddr = root_ff;
            size_a_in  = size_q_ff;
            state_in   = ST_SZC;
         end
         ST_SZC: begin
            // link the first root under the second and add sizes
            if (root_a_ff == root_ff) begin
               res_in = size_a_ff;
            end else begin
               res_in     = size_sum;
               par_we     = 1'b1;
               par_waddr  = root_a_ff;
               par_wdata  = root_ff;
               size_we    = 1'b1;
               size_waddr = root_ff;
               size_wdata = size_sum;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // advance from the first walk to the second, or on to the sizes
      if (phase_done) begin
         root_in = fin_root;
         if (!phase_b_ff) begin
            root_a_in  = fin_root;
            phase_b_in = 1'b1;
            cur_in     = node_b_ff;
            start_in   = node_b_ff;
            par_raddr  = node_b_ff;
            state_in   = ST_FIND;
         end else begin
            state_in = ST_SZA;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         clr_item_ff  <= 1'b0;
         phase_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_item_ff  <= clr_item_in;
         phase_b_ff   <= phase_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      node_b_ff   <= node_b_in;
      root_a_ff   <= root_a_in;
      root_ff     <= root_in;
      size_a_ff   <= size_a_in;
      res_ff      <= res_in;
      rsp_size_ff <= rsp_size_in;
   end

   // Parent memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem_ff[par_waddr] <= par_wdata;
      end
      par_q_ff <= par_mem_ff[par_raddr];
   end

   // Size memory; a root that goes under another keeps a stale size it never shows
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem_ff[size_waddr] <= size_wdata;
      end
      size_q_ff <= size_mem_ff[size_raddr];
   end

   // Checks
   `UF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `UF_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
   `UF_ASSERT(a_walk_in_range, clock, reset, (state_ff == ST_FIND || state_ff == ST_COMP) |-> CMP_W'(cur_ff) < NODES_LIM)
   `UF_ASSERT(a_link_roots_in_range, clock, reset, (state_ff == ST_SZC) |-> (CMP_W'(root_a_ff) < NODES_LIM && CMP_W'(root_ff) < NODES_LIM))

endmodule

/* tb/sv/ufss_tb_pkg.sv */
// Operation codes shared by the union-find set-size testbench files.
`timescale 1ns / 1ps
package ufss_tb_pkg;

   // Meaning of the mode bit carried on req_tuser.
   typedef enum logic {
      OP_LINK  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

endpackage

/* tb/sv/ufss_checker.sv */
// Checker that tracks the disjoint-set store and compares every set-size result item.
`timescale 1ns / 1ps
module ufss_checker
   import ufss_pkg::*;
   import ufss_tb_pkg::*;
#(
   parameter int NODES = NODES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // node_a [9:0], node_b [19:10], zero pad
   input  logic                  req_tuser,   // mode [0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // set_size [10:0], zero pad
   output int                    fail_count,
   output int                    pending
);

   // Shadow copy of the store: parent link and set size per element.
   int parent_of [NODES];
   int set_count [NODES];

   logic [SIZE_W-1:0] expected_sizes [$];
   int errors = 0;
   int awaited = 0;
   int results_seen = 0;

   assign fail_count = errors;
   assign pending    = awaited;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Make every element its own singleton set.
   function automatic void make_singletons();
      int idx;
      for (idx = 0; idx < NODES; idx++) begin
         parent_of[idx] = idx;
         set_count[idx] = 1;
      end
   endfunction

   // Walk up to the root, then point every element on the path at it.
   function automatic int find_root(input int start);
      int root_idx;
      int cur;
      int nxt;
      int steps;
      root_idx = start;
      steps = 0;
      while (steps < NODES && parent_of[root_idx] != root_idx) begin
         nxt = parent_of[root_idx];
         if (nxt >= NODES)
            break;
         root_idx = nxt;
         steps++;
      end
      cur = start;
      steps = 0;
      while (steps < NODES && cur != root_idx) begin
         nxt = parent_of[cur];
         parent_of[cur] = root_idx;
         if (nxt >= NODES)
            break;
         cur = nxt;
         steps++;
      end
      return root_idx;
   endfunction

   // Apply one request item to the shadow store and return its set size.
   function automatic logic [SIZE_W-1:0] predict_set_size(input op_type op,
                                                           input int node_a,
                                                           input int node_b);
      int root_a;
      int root_b;
      int total;
      if (op == OP_CLEAR) begin
         make_singletons();
         return '0;
      end
      if (node_a >= NODES || node_b >= NODES)
         return '0;
      root_a = find_root(node_a);
      root_b = find_root(node_b);
      if (root_a == root_b) begin
         total = set_count[root_a];
      end else begin
         // first root goes under the second, sizes merge
         total = set_count[root_a] + set_count[root_b];
         parent_of[root_a] = root_b;
         set_count[root_b] = total;
         set_count[root_a] = 0;
      end
      return total[SIZE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         make_singletons();
         expected_sizes.delete();
      end else begin
         // compare result item with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sizes.size() == 0) begin
               report_mismatch($sformatf("result %0d: set_size %0d with none awaited",
                                         results_seen, rsp_tdata[SIZE_W-1:0]));
            end else if (rsp_tdata[SIZE_W-1:0] !== expected_sizes[0]) begin
               report_mismatch($sformatf("result %0d: set_size %0d, want %0d",
                                         results_seen, rsp_tdata[SIZE_W-1:0],
                                         expected_sizes[0]));
               void'(expected_sizes.pop_front());
            end else begin
               void'(expected_sizes.pop_front());
            end
            results_seen++;
         end
         // predict the accepted request item
         if (req_tvalid && req_tready)
            expected_sizes.push_back(predict_set_size(op_type'(req_tuser),
                                                      int'(req_tdata[NODE_W-1:0]),
                                                      int'(req_tdata[2*NODE_W-1:NODE_W])));
      end
      awaited <= expected_sizes.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// Top of the union-find set-size testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top
   import ufss_pkg::*;
   import ufss_tb_pkg::*;
();

   localparam int LIMIT_CYCLES    = 1_500_000;
   localparam int PRESSURE_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 2 * NODES_DEF + 16;
   localparam int WINDOW_ITEMS    = 360;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // node_a [9:0], node_b [19:10], zero pad
   logic                  req_tuser = 1'b0; // mode [0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // set_size [10:0], zero pad

   int fail_count;
   int pending;
   int cycle_count = 0;
   bit pressure_go = 1'b0;
   int calm_left = 0;
   bit calm = 1'b0;
   int node_order [NODES_DEF];

   union_find_set_size #(.NODES(NODES_DEF)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ufss_checker #(.NODES(NODES_DEF)) chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("union_find_set_size: mismatch");
         $finish;
      end
   end

   // Mostly no pause, sometimes a short one, rarely a long one.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input op_type op, input logic [NODE_W-1:0] node_a,
                            input logic [NODE_W-1:0] node_b);
      int gap;
      if (calm_left == 0) begin
         calm = ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(20, 60);
      end
      calm_left--;
      gap = calm ? 0 : idle_cycles();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - 2 * NODE_W){1'b0}}, node_b, node_a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (pressure_go) begin
            pressure_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end else begin
            stall = idle_cycles();
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(50, 150)) @(posedge clock);
            else
               repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      int base;
      int span;
      int roll;
      int idx;
      int j;
      int tmp;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, same element, same set, chains, clears.
      send_item(OP_CLEAR, '1, '1);
      send_item(OP_LINK, 10'd0, 10'd0);
      send_item(OP_LINK, 10'd1023, 10'd1023);
      send_item(OP_LINK, 10'd0, 10'd1023);
      send_item(OP_LINK, 10'd1023, 10'd0);
      send_item(OP_LINK, 10'h155, 10'h2AA);
      send_item(OP_LINK, 10'h2AA, 10'h155);
      send_item(OP_LINK, 10'd5, 10'd6);
      send_item(OP_LINK, 10'd6, 10'd7);
      send_item(OP_LINK, 10'd7, 10'd8);
      send_item(OP_LINK, 10'd8, 10'd9);
      send_item(OP_LINK, 10'd5, 10'd0);
      send_item(OP_LINK, 10'd9, 10'd5);
      send_item(OP_LINK, 10'h2AA, 10'd1023);
      send_item(OP_LINK, 10'd6, 10'h155);
      send_item(OP_CLEAR, 10'd0, 10'd0);
      send_item(OP_LINK, 10'd0, 10'd1023);
      send_item(OP_LINK, 10'h3FE, 10'h001);
      send_item(OP_CLEAR, 10'h2AA, 10'h155);
      send_item(OP_LINK, 10'd9, 10'd5);

      // Random links inside a moving window so sets grow and meet.
      base = 0;
      span = 4;
      for (idx = 0; idx < WINDOW_ITEMS; idx++) begin
         if (idx % 40 == 0) begin
            base = $urandom_range(0, NODES_DEF - 1);
            span = 4 << (2 * $urandom_range(0, 2));
         end
         if (idx == 40)
            pressure_go = 1'b1;
         roll = $urandom_range(0, 99);
         node_a = NODE_W'(base + $urandom_range(0, span - 1));
         node_b = NODE_W'(base + $urandom_range(0, span - 1));
         if (roll < 2) begin
            send_item(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
         end else if (roll < 8) begin
            send_item(OP_LINK, NODE_W'($urandom), NODE_W'($urandom));
         end else begin
            send_item(OP_LINK, node_a, node_b);
         end
      end

      // Merge the whole store along a shuffled order; long chains build up.
      send_item(OP_CLEAR, 10'd0, 10'd0);
      for (idx = 0; idx < NODES_DEF; idx++)
         node_order[idx] = idx;
      for (idx = NODES_DEF - 1; idx > 0; idx--) begin
         j = $urandom_range(0, idx);
         tmp = node_order[idx];
         node_order[idx] = node_order[j];
         node_order[j] = tmp;
      end
      for (idx = 0; idx < NODES_DEF - 1; idx++) begin
         if ($urandom_range(0, 1) == 1)
            send_item(OP_LINK, NODE_W'(node_order[idx]), NODE_W'(node_order[idx + 1]));
         else
            send_item(OP_LINK, NODE_W'(node_order[idx + 1]), NODE_W'(node_order[idx]));
      end

      // Queries on the full set, then a fresh store.
      for (idx = 0; idx < 10; idx++)
         send_item(OP_LINK, NODE_W'($urandom), NODE_W'($urandom));
      send_item(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
      for (idx = 0; idx < 10; idx++)
         send_item(OP_LINK, NODE_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 7)));
      req_tvalid <= 1'b0;

      // Drain outstanding results, then allow for late extras.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("union_find_set_size: match");
      else
         $display("union_find_set_size: mismatch");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ufss_pkg.sv
rtl/core/union_find_set_size.sv
tb/sv/ufss_tb_pkg.sv
tb/sv/ufss_checker.sv
tb/sv/tb_top.sv
